FILE: rtl/cpu8_alu_pkg.sv
// Package with operation codes, status bit positions and reset values of the execute stage.
package cpu8_alu_pkg;

   localparam int REQ_W = 16;
   localparam int RSP_W = 56;

   localparam logic [7:0] ACC_RESET    = 8'h00;
   localparam logic [7:0] SP_RESET     = 8'hFD;
   localparam logic [7:0] STATUS_RESET = 8'h24;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_5 = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   typedef enum logic [5:0] {
      CMD_ADC   = 6'd0,
      CMD_SBC   = 6'd1,
      CMD_AND   = 6'd2,
      CMD_ORA   = 6'd3,
      CMD_EOR   = 6'd4,
      CMD_CMP   = 6'd5,
      CMD_CPX   = 6'd6,
      CMD_CPY   = 6'd7,
      CMD_BIT   = 6'd8,
      CMD_LDA   = 6'd9,
      CMD_LDX   = 6'd10,
      CMD_LDY   = 6'd11,
      CMD_LAX   = 6'd12,
      CMD_ASL_A = 6'd13,
      CMD_LSR_A = 6'd14,
      CMD_ROL_A = 6'd15,
      CMD_ROR_A = 6'd16,
      CMD_ASL_M = 6'd17,
      CMD_LSR_M = 6'd18,
      CMD_ROL_M = 6'd19,
      CMD_ROR_M = 6'd20,
      CMD_INC   = 6'd21,
      CMD_DEC   = 6'd22,
      CMD_INX   = 6'd23,
      CMD_INY   = 6'd24,
      CMD_DEX   = 6'd25,
      CMD_DEY   = 6'd26,
      CMD_TAX   = 6'd27,
      CMD_TAY   = 6'd28,
      CMD_TSX   = 6'd29,
      CMD_TXA   = 6'd30,
      CMD_TXS   = 6'd31,
      CMD_TYA   = 6'd32,
      CMD_CLC   = 6'd33,
      CMD_SEC   = 6'd34,
      CMD_CLD   = 6'd35,
      CMD_SED   = 6'd36,
      CMD_CLI   = 6'd37,
      CMD_SEI   = 6'd38,
      CMD_CLV   = 6'd39,
      CMD_DCP   = 6'd40,
      CMD_ISB   = 6'd41,
      CMD_SLO   = 6'd42,
      CMD_RLA   = 6'd43,
      CMD_SRE   = 6'd44,
      CMD_RRA   = 6'd45,
      CMD_STA   = 6'd46,
      CMD_STX   = 6'd47,
      CMD_STY   = 6'd48,
      CMD_SAX   = 6'd49,
      CMD_PLP   = 6'd50
   } cmd_type;

endpackage

FILE: rtl/cpu8_alu_register_execute_top.sv
// Execute stage of an 8-bit processor: A, X, Y, SP, status and the ALU.
//
// Input channel req_*: one item per operation, an operation code and the
// byte already fetched for it. Result channel rsp_*: one item per input
// item, carrying the memory write byte and strobe and the register file
// and status after the operation.
// An item is captured in the input register, executed by one pass of
// combinational logic against the register file and captured in the
// result register, which drives rsp_tvalid. Throughput is one item per
// cycle while rsp_tready is high; the register file is updated in the
// same edge that loads the result register, so the next item sees it.
// When rsp_tready is low the result holds, the input register holds the
// next item, and req_tready falls only once both are occupied.
// Synchronous reset sets A, X, Y to 0, SP to 0xFD, status to 0x24 and
// empties both registers.
// Unused operation codes return the unchanged registers with no write.
module cpu8_alu_register_execute_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [5:0] command, [13:6] operand, [15:14] zero
   input  logic [cpu8_alu_pkg::REQ_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] mem_data, [8] mem_write, [16:9] acc_out, [24:17] x_out,
   // [32:25] y_out, [40:33] sp_out, [48:41] status_out, [55:49] zero
   output logic [cpu8_alu_pkg::RSP_W-1:0] rsp_tdata
);
   import cpu8_alu_pkg::*;

   logic       req_valid_ff, req_valid_in;
   logic [5:0] req_cmd_ff;
   logic [7:0] req_opd_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [7:0] acc_ff, acc_in;
   logic [7:0] x_ff, x_in;
   logic [7:0] y_ff, y_in;
   logic [7:0] sp_ff, sp_in;
   logic [7:0] p_ff, p_in;

   logic       accept;
   logic       advance;

   logic [7:0] op;
   logic [7:0] op_inc;
   logic [7:0] op_dec;
   logic [7:0] shf_src;
   logic [7:0] asl_v, lsr_v, rol_v, ror_v;
   logic [7:0] add_m;
   logic       add_cin;
   logic [8:0] add_sum;
   logic       add_v;
   logic [7:0] cmp_r, cmp_b;
   logic [8:0] cmp_diff;
   logic [7:0] wdata;
   logic       wr;

   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r         = p;
      r[FLAG_Z] = (v == 8'h00);
      r[FLAG_N] = v[7];
      return r;
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (accept) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // shared datapath pieces
   assign op     = req_opd_ff;
   assign op_inc = op + 8'd1;
   assign op_dec = op - 8'd1;

   always_comb begin
      case (cmd_type'(req_cmd_ff))
         CMD_ASL_A, CMD_LSR_A, CMD_ROL_A, CMD_ROR_A: shf_src = acc_ff;
         default:                                    shf_src = op;
      endcase
   end

   assign asl_v = {shf_src[6:0], 1'b0};
   assign lsr_v = {1'b0, shf_src[7:1]};
   assign rol_v = {shf_src[6:0], p_ff[FLAG_C]};
   assign ror_v = {p_ff[FLAG_C], shf_src[7:1]};

   always_comb begin
      add_cin = p_ff[FLAG_C];
      case (cmd_type'(req_cmd_ff))
         CMD_SBC: add_m = ~op;
         CMD_ISB: add_m = ~op_inc;
         CMD_RRA: begin
            // add with the carry that the rotate shifted out
            add_m   = ror_v;
            add_cin = op[0];
         end
         default: add_m = op;
      endcase
   end

   assign add_sum = {1'b0, acc_ff} + {1'b0, add_m} + {8'h00, add_cin};
   assign add_v   = ~(acc_ff[7] ^ add_m[7]) & (acc_ff[7] ^ add_sum[7]);

   always_comb begin
      cmp_b = op;
      case (cmd_type'(req_cmd_ff))
         CMD_CPX: cmp_r = x_ff;
         CMD_CPY: cmp_r = y_ff;
         CMD_DCP: begin
            cmp_r = acc_ff;
            cmp_b = op_dec;
         end
         default: cmp_r = acc_ff;
      endcase
   end

   assign cmp_diff = {1'b0, cmp_r} - {1'b0, cmp_b};

   always_comb begin
      acc_in = acc_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      sp_in  = sp_ff;
      p_in   = p_ff;
      wdata  = 8'h00;
      wr     = 1'b0;
      unique case (cmd_type'(req_cmd_ff))
         CMD_ADC, CMD_SBC, CMD_ISB, CMD_RRA: begin
            acc_in         = add_sum[7:0];
            p_in[FLAG_C]   = add_sum[8];
            p_in[FLAG_V]   = add_v;
            p_in           = set_nz(p_in, add_sum[7:0]);
            if (cmd_type'(req_cmd_ff) == CMD_ISB) begin
               wdata = op_inc;
               wr    = 1'b1;
            end else if (cmd_type'(req_cmd_ff) == CMD_RRA) begin
               wdata = ror_v;
               wr    = 1'b1;
            end
         end
         CMD_AND: begin
            acc_in = acc_ff & op;
            p_in   = set_nz(p_ff, acc_ff & op);
         end
         CMD_ORA: begin
            acc_in = acc_ff | op;
            p_in   = set_nz(p_ff, acc_ff | op);
         end
         CMD_EOR: begin
            acc_in = acc_ff ^ op;
            p_in   = set_nz(p_ff, acc_ff ^ op);
         end
         CMD_CMP, CMD_CPX, CMD_CPY, CMD_DCP: begin
            p_in[FLAG_C] = !cmp_diff[8];
            p_in[FLAG_Z] = (cmp_r == cmp_b);
            p_in[FLAG_N] = cmp_diff[7];
            if (cmd_type'(req_cmd_ff) == CMD_DCP) begin
               wdata = op_dec;
               wr    = 1'b1;
            end
         end
         CMD_BIT: begin
            p_in[FLAG_N] = op[7];
            p_in[FLAG_V] = op[6];
            p_in[FLAG_Z] = ((op & acc_ff) == 8'h00);
         end
         CMD_LDA: begin
            acc_in = op;
            p_in   = set_nz(p_ff, op);
         end
         CMD_LDX: begin
            x_in = op;
            p_in = set_nz(p_ff, op);
         end
         CMD_LDY: begin
            y_in = op;
            p_in = set_nz(p_ff, op);
         end
         CMD_LAX: begin
            acc_in = op;
            x_in   = op;
            p_in   = set_nz(p_ff, op);
         end
         CMD_ASL_A: begin
            acc_in       = asl_v;
            p_in         = set_nz(p_ff, asl_v);
            p_in[FLAG_C] = shf_src[7];
         end
         CMD_LSR_A: begin
            acc_in       = lsr_v;
            p_in         = set_nz(p_ff, lsr_v);
            p_in[FLAG_C] = shf_src[0];
         end
         CMD_ROL_A: begin
            acc_in       = rol_v;
            p_in         = set_nz(p_ff, rol_v);
            p_in[FLAG_C] = shf_src[7];
         end
         CMD_ROR_A: begin
            acc_in       = ror_v;
            p_in         = set_nz(p_ff, ror_v);
            p_in[FLAG_C] = shf_src[0];
         end
         CMD_ASL_M: begin
            wdata        = asl_v;
            wr           = 1'b1;
            p_in         = set_nz(p_ff, asl_v);
            p_in[FLAG_C] = op[7];
         end
         CMD_LSR_M: begin
            wdata        = lsr_v;
            wr           = 1'b1;
            p_in         = set_nz(p_ff, lsr_v);
            p_in[FLAG_C] = op[0];
         end
         CMD_ROL_M: begin
            wdata        = rol_v;
            wr           = 1'b1;
            p_in         = set_nz(p_ff, rol_v);
            p_in[FLAG_C] = op[7];
         end
         CMD_ROR_M: begin
            wdata        = ror_v;
            wr           = 1'b1;
            p_in         = set_nz(p_ff, ror_v);
            p_in[FLAG_C] = op[0];
         end
         CMD_INC: begin
            wdata = op_inc;
            wr    = 1'b1;
            p_in  = set_nz(p_ff, op_inc);
         end
         CMD_DEC: begin
            wdata = op_dec;
            wr    = 1'b1;
            p_in  = set_nz(p_ff, op_dec);
         end
         CMD_INX: begin
            x_in = x_ff + 8'd1;
            p_in = set_nz(p_ff, x_ff + 8'd1);
         end
         CMD_INY: begin
            y_in = y_ff + 8'd1;
            p_in = set_nz(p_ff, y_ff + 8'd1);
         end
         CMD_DEX: begin
            x_in = x_ff - 8'd1;
            p_in = set_nz(p_ff, x_ff - 8'd1);
         end
         CMD_DEY: begin
            y_in = y_ff - 8'd1;
            p_in = set_nz(p_ff, y_ff - 8'd1);
         end
         CMD_TAX: begin
            x_in = acc_ff;
            p_in = set_nz(p_ff, acc_ff);
         end
         CMD_TAY: begin
            y_in = acc_ff;
            p_in = set_nz(p_ff, acc_ff);
         end
         CMD_TSX: begin
            x_in = sp_ff;
            p_in = set_nz(p_ff, sp_ff);
         end
         CMD_TXA: begin
            acc_in = x_ff;
            p_in   = set_nz(p_ff, x_ff);
         end
         CMD_TXS: sp_in = x_ff;
         CMD_TYA: begin
            acc_in = y_ff;
            p_in   = set_nz(p_ff, y_ff);
         end
         CMD_CLC: p_in[FLAG_C] = 1'b0;
         CMD_SEC: p_in[FLAG_C] = 1'b1;
         CMD_CLD: p_in[FLAG_D] = 1'b0;
         CMD_SED: p_in[FLAG_D] = 1'b1;
         CMD_CLI: p_in[FLAG_I] = 1'b0;
         CMD_SEI: p_in[FLAG_I] = 1'b1;
         CMD_CLV: p_in[FLAG_V] = 1'b0;
         CMD_SLO: begin
            wdata        = asl_v;
            wr           = 1'b1;
            acc_in       = acc_ff | asl_v;
            p_in         = set_nz(p_ff, acc_ff | asl_v);
            p_in[FLAG_C] = op[7];
         end
         CMD_RLA: begin
            wdata        = rol_v;
            wr           = 1'b1;
            acc_in       = acc_ff & rol_v;
            p_in         = set_nz(p_ff, acc_ff & rol_v);
            p_in[FLAG_C] = op[7];
         end
         CMD_SRE: begin
            wdata        = lsr_v;
            wr           = 1'b1;
            acc_in       = acc_ff ^ lsr_v;
            p_in         = set_nz(p_ff, acc_ff ^ lsr_v);
            p_in[FLAG_C] = op[0];
         end
         CMD_STA: begin
            wdata = acc_ff;
            wr    = 1'b1;
         end
         CMD_STX: begin
            wdata = x_ff;
            wr    = 1'b1;
         end
         CMD_STY: begin
            wdata = y_ff;
            wr    = 1'b1;
         end
         CMD_SAX: begin
            wdata = acc_ff & x_ff;
            wr    = 1'b1;
         end
         CMD_PLP: begin
            // keep B and the always-one bit from the current status
            p_in         = op;
            p_in[FLAG_B] = p_ff[FLAG_B];
            p_in[FLAG_5] = p_ff[FLAG_5];
         end
         default: begin
         end
      endcase
   end

   assign rsp_data_in = {7'b0000000, p_in, sp_in, y_in, x_in, acc_in, wr, wdata};

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= ACC_RESET;
         x_ff         <= ACC_RESET;
         y_ff         <= ACC_RESET;
         sp_ff        <= SP_RESET;
         p_ff         <= STATUS_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            acc_ff <= acc_in;
            x_ff   <= x_in;
            y_ff   <= y_in;
            sp_ff  <= sp_in;
            p_ff   <= p_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_cmd_ff <= req_tdata[5:0];
         req_opd_ff <= req_tdata[13:6];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a shown result always matches the register file it left behind
   a_rsp_matches_state : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[16:9] == acc_ff && rsp_data_ff[24:17] == x_ff &&
                        rsp_data_ff[32:25] == y_ff && rsp_data_ff[40:33] == sp_ff &&
                        rsp_data_ff[48:41] == p_ff))
      else $error("result register out of step with register file");

   a_no_write_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[8]) |-> (rsp_data_ff[7:0] == 8'h00))
      else $error("write byte nonzero without write strobe");

   a_status_fixed_bits : assert property (@(posedge clock) disable iff (reset)
      (p_ff[FLAG_5] && !p_ff[FLAG_B]))
      else $error("status B or always-one bit changed");

   a_state_holds_idle : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(acc_ff) && $stable(x_ff) && $stable(p_ff))
      else $error("register file changed without an item");

endmodule

FILE: sim/cpu8_alu_register_execute_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 8-bit execute stage: directed and random items vs a predictor.
module cpu8_alu_register_execute_top_tb;
   import cpu8_alu_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int TAIL_CYCLES = 10;
   localparam int HOLD_CYCLES = 60;
   localparam int MAX_REPORTS = 10;
   localparam logic [5:0] CMD_UNUSED_LO = 6'd51;
   localparam logic [5:0] CMD_UNUSED_HI = 6'd63;

   typedef enum logic [1:0] {SHIFT_ASL, SHIFT_LSR, SHIFT_ROL, SHIFT_ROR} shift_kind_type;

   typedef struct {
      logic [7:0] mem_data;
      logic       mem_write;
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] status;
   } exec_state_type;

   class execute_tracker;
      logic [7:0]  acc;
      logic [7:0]  idx_x;
      logic [7:0]  idx_y;
      logic [7:0]  sp;
      logic [7:0]  flags;
      exec_state_type predicted_outputs[$];
      int          errors;
      int          results_seen;

      function new();
         acc = ACC_RESET;
         idx_x = 8'h00;
         idx_y = 8'h00;
         sp = SP_RESET;
         flags = STATUS_RESET;
         errors = 0;
         results_seen = 0;
      endfunction

      function void set_nz(logic [7:0] v);
         flags[FLAG_N] = v[7];
         flags[FLAG_Z] = (v == 8'h00);
      endfunction

      function void sum_into_acc(logic [7:0] b);
         logic [8:0] sum;
         sum = {1'b0, acc} + {1'b0, b} + {8'h00, flags[FLAG_C]};
         flags[FLAG_C] = sum[8];
         flags[FLAG_V] = ~(acc[7] ^ b[7]) & (acc[7] ^ sum[7]);
         acc = sum[7:0];
         set_nz(acc);
      endfunction

      function void compare_with(logic [7:0] r, logic [7:0] b);
         logic [7:0] diff;
         diff = r - b;
         flags[FLAG_C] = (r >= b);
         flags[FLAG_Z] = (r == b);
         flags[FLAG_N] = diff[7];
      endfunction

      // carry takes the bit shifted out; rotates bring the old carry in
      function logic [7:0] shift_byte(logic [7:0] v, shift_kind_type kind);
         logic       cin;
         logic [7:0] r;
         cin = flags[FLAG_C];
         case (kind)
            SHIFT_ASL: begin
               flags[FLAG_C] = v[7];
               r = {v[6:0], 1'b0};
            end
            SHIFT_ROL: begin
               flags[FLAG_C] = v[7];
               r = {v[6:0], cin};
            end
            SHIFT_LSR: begin
               flags[FLAG_C] = v[0];
               r = {1'b0, v[7:1]};
            end
            default: begin
               flags[FLAG_C] = v[0];
               r = {cin, v[7:1]};
            end
         endcase
         return r;
      endfunction

      function exec_state_type execute_op(logic [5:0] cmd, logic [7:0] op);
         exec_state_type res;
         logic [7:0]  wdata;
         logic        wr;
         logic [7:0]  keep;
         wdata = 8'h00;
         wr = 1'b0;
         keep = (8'h01 << FLAG_B) | (8'h01 << FLAG_5);
         case (cmd)
            CMD_ADC: sum_into_acc(op);
            CMD_SBC: sum_into_acc(~op);
            CMD_AND: begin acc &= op; set_nz(acc); end
            CMD_ORA: begin acc |= op; set_nz(acc); end
            CMD_EOR: begin acc ^= op; set_nz(acc); end
            CMD_CMP: compare_with(acc, op);
            CMD_CPX: compare_with(idx_x, op);
            CMD_CPY: compare_with(idx_y, op);
            CMD_BIT: begin
               flags[FLAG_N] = op[7];
               flags[FLAG_V] = op[6];
               flags[FLAG_Z] = ((op & acc) == 8'h00);
            end
            CMD_LDA: begin acc = op; set_nz(op); end
            CMD_LDX: begin idx_x = op; set_nz(op); end
            CMD_LDY: begin idx_y = op; set_nz(op); end
            CMD_LAX: begin acc = op; idx_x = op; set_nz(op); end
            CMD_ASL_A: begin acc = shift_byte(acc, SHIFT_ASL); set_nz(acc); end
            CMD_LSR_A: begin acc = shift_byte(acc, SHIFT_LSR); set_nz(acc); end
            CMD_ROL_A: begin acc = shift_byte(acc, SHIFT_ROL); set_nz(acc); end
            CMD_ROR_A: begin acc = shift_byte(acc, SHIFT_ROR); set_nz(acc); end
            CMD_ASL_M: begin wdata = shift_byte(op, SHIFT_ASL); wr = 1'b1; set_nz(wdata); end
            CMD_LSR_M: begin wdata = shift_byte(op, SHIFT_LSR); wr = 1'b1; set_nz(wdata); end
            CMD_ROL_M: begin wdata = shift_byte(op, SHIFT_ROL); wr = 1'b1; set_nz(wdata); end
            CMD_ROR_M: begin wdata = shift_byte(op, SHIFT_ROR); wr = 1'b1; set_nz(wdata); end
            CMD_INC: begin wdata = op + 8'd1; wr = 1'b1; set_nz(wdata); end
            CMD_DEC: begin wdata = op - 8'd1; wr = 1'b1; set_nz(wdata); end
            CMD_INX: begin idx_x = idx_x + 8'd1; set_nz(idx_x); end
            CMD_INY: begin idx_y = idx_y + 8'd1; set_nz(idx_y); end
            CMD_DEX: begin idx_x = idx_x - 8'd1; set_nz(idx_x); end
            CMD_DEY: begin idx_y = idx_y - 8'd1; set_nz(idx_y); end
            CMD_TAX: begin idx_x = acc; set_nz(idx_x); end
            CMD_TAY: begin idx_y = acc; set_nz(idx_y); end
            CMD_TSX: begin idx_x = sp; set_nz(idx_x); end
            CMD_TXA: begin acc = idx_x; set_nz(acc); end
            CMD_TXS: sp = idx_x;
            CMD_TYA: begin acc = idx_y; set_nz(acc); end
            CMD_CLC: flags[FLAG_C] = 1'b0;
            CMD_SEC: flags[FLAG_C] = 1'b1;
            CMD_CLD: flags[FLAG_D] = 1'b0;
            CMD_SED: flags[FLAG_D] = 1'b1;
            CMD_CLI: flags[FLAG_I] = 1'b0;
            CMD_SEI: flags[FLAG_I] = 1'b1;
            CMD_CLV: flags[FLAG_V] = 1'b0;
            CMD_DCP: begin wdata = op - 8'd1; wr = 1'b1; compare_with(acc, wdata); end
            CMD_ISB: begin wdata = op + 8'd1; wr = 1'b1; sum_into_acc(~wdata); end
            // combined ops work on the shifted byte, not the operand
            CMD_SLO: begin
               wdata = shift_byte(op, SHIFT_ASL); wr = 1'b1;
               acc |= wdata; set_nz(acc);
            end
            CMD_RLA: begin
               wdata = shift_byte(op, SHIFT_ROL); wr = 1'b1;
               acc &= wdata; set_nz(acc);
            end
            CMD_SRE: begin
               wdata = shift_byte(op, SHIFT_LSR); wr = 1'b1;
               acc ^= wdata; set_nz(acc);
            end
            CMD_RRA: begin
               wdata = shift_byte(op, SHIFT_ROR); wr = 1'b1;
               sum_into_acc(wdata);
            end
            CMD_STA: begin wdata = acc; wr = 1'b1; end
            CMD_STX: begin wdata = idx_x; wr = 1'b1; end
            CMD_STY: begin wdata = idx_y; wr = 1'b1; end
            CMD_SAX: begin wdata = acc & idx_x; wr = 1'b1; end
            // keep B and bit 5 from the current status
            CMD_PLP: flags = (op & ~keep) | (flags & keep);
            default: ;
         endcase
         res.mem_data = wr ? wdata : 8'h00;
         res.mem_write = wr;
         res.acc = acc;
         res.x = idx_x;
         res.y = idx_y;
         res.sp = sp;
         res.status = flags;
         return res;
      endfunction

      function void note_command(logic [5:0] cmd, logic [7:0] op);
         predicted_outputs.push_back(execute_op(cmd, op));
      endfunction

      function int pending();
         return predicted_outputs.size();
      endfunction

      function void check_field(string what, logic [7:0] exp, logic [7:0] act);
         if (act !== exp) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("result %0d: %s expected %02h got %02h", results_seen, what, exp, act);
         end
      endfunction

      function void check_result(logic [RSP_W-1:0] data);
         exec_state_type exp;
         results_seen++;
         if (predicted_outputs.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("result %0d: arrived with nothing expected, data %014h",
                        results_seen, data);
            return;
         end
         exp = predicted_outputs.pop_front();
         check_field("mem_data", exp.mem_data, data[7:0]);
         check_field("mem_write", {7'b0, exp.mem_write}, {7'b0, data[8]});
         check_field("acc_out", exp.acc, data[16:9]);
         check_field("x_out", exp.x, data[24:17]);
         check_field("y_out", exp.y, data[32:25]);
         check_field("sp_out", exp.sp, data[40:33]);
         check_field("status_out", exp.status, data[48:41]);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // [5:0] command, [13:6] operand, [15:14] zero
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // [7:0] mem_data, [8] mem_write, [16:9] acc_out, [24:17] x_out,
   // [32:25] y_out, [40:33] sp_out, [48:41] status_out, [55:49] zero
   logic [RSP_W-1:0] rsp_tdata;

   logic           idle_enable;
   logic           hold_request;
   execute_tracker tracker;

   cpu8_alu_register_execute_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata);
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stalled = 0;
         else
            stalled++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      int idle_left;
      idle_left = 0;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         if (idle_left > 0) begin
            rsp_tready <= 1'b0;
            idle_left--;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            idle_left = $urandom_range(0, 8);
         end else begin
            rsp_tready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   task automatic send_item(input logic [5:0] cmd, input logic [7:0] operand);
      int gap;
      gap = 0;
      if (idle_enable && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 9);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({operand, cmd});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_command(cmd, operand);
   endtask

   task automatic send_random(input int count);
      logic [5:0] cmd;
      logic [7:0] operand;
      repeat (count) begin
         if ($urandom_range(0, 15) == 0)
            cmd = 6'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
         else
            cmd = 6'($urandom_range(CMD_ADC, CMD_PLP));
         // lean on the byte extremes that flip carry, overflow and sign
         case ($urandom_range(0, 7))
            0: operand = 8'h00;
            1: operand = 8'hFF;
            2: operand = 8'h80;
            3: operand = 8'h7F;
            default: operand = 8'($urandom_range(0, 255));
         endcase
         send_item(cmd, operand);
      end
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      idle_enable = 1'b1;
      hold_request = 1'b0;
      tracker = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(CMD_LDA, 8'h00);
      send_item(CMD_LDA, 8'hFF);
      send_item(CMD_LDX, 8'h80);
      send_item(CMD_LDY, 8'h7F);
      send_item(CMD_CLC, 8'h00);
      send_item(CMD_LDA, 8'h7F);
      send_item(CMD_ADC, 8'h01);
      send_item(CMD_ADC, 8'hFF);
      send_item(CMD_SEC, 8'h00);
      send_item(CMD_SBC, 8'h80);
      send_item(CMD_CMP, 8'hFF);
      send_item(CMD_BIT, 8'hC0);
      // decimal flag set, add stays binary
      send_item(CMD_SED, 8'h00);
      send_item(CMD_ADC, 8'h99);
      send_item(CMD_SLO, 8'h81);
      send_item(CMD_SEC, 8'h00);
      send_item(CMD_RLA, 8'hFF);
      send_item(CMD_SRE, 8'h01);
      send_item(CMD_RRA, 8'h01);
      send_item(CMD_DCP, 8'h00);
      send_item(CMD_ISB, 8'hFF);
      send_item(CMD_PLP, 8'hFF);
      send_item(CMD_SAX, 8'h00);
      send_item(CMD_UNUSED_HI, 8'hFF);
      send_item(CMD_PLP, 8'h00);
      drain_pipeline();

      send_random(150);
      // stall the result side long enough to back up the input
      hold_request = 1'b1;
      send_random(150);
      drain_pipeline();
      send_random(300);
      idle_enable = 1'b0;
      send_random(400);
      drain_pipeline();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: files.f
rtl/cpu8_alu_pkg.sv
rtl/cpu8_alu_register_execute_top.sv
sim/cpu8_alu_register_execute_top_tb.sv
